// ===== sv/cau_pkg.sv =====
// Shared package for the complex arithmetic unit: operation codes and default widths.
// No dependencies; imported by every module of the block.
package cau_pkg;

    localparam int DataWidthDef = 16;
    localparam int FracBitsDef  = 8;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_op;

endpackage

// ===== sv/cau_divider.sv =====
// Pipelined restoring divider for the complex arithmetic unit, one quotient bit per stage.
// Depends on cau_pkg. Divides two signed numerators by one positive denominator.
module cau_divider #(
    parameter int NW = 34,
    parameter int DW = 33,
    parameter int FB = 8,
    parameter int QW = 17,
    parameter int TW = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [TW-1:0]        i_tag,
    input  logic                 i_neg_re,
    input  logic [NW-1:0]        i_mag_re,
    input  logic                 i_neg_im,
    input  logic [NW-1:0]        i_mag_im,
    input  logic [DW-1:0]        i_den,
    output logic                 o_valid,
    output logic [TW-1:0]        o_tag,
    output logic                 o_neg_re,
    output logic [QW-1:0]        o_q_re,
    output logic                 o_neg_im,
    output logic [QW-1:0]        o_q_im
);
    import cau_pkg::*;

    // The quotient of numerator*2^FB by den, capped at 2^(QW-1); NW+FB bit steps.
    localparam int NS = NW + FB;
    localparam int RW = DW + 1;

    logic [NS:0]          r_vld;
    logic [TW-1:0]        r_tag   [NS+1];
    logic [DW-1:0]        r_den   [NS+1];
    logic                 r_ngr   [NS+1];
    logic                 r_ngi   [NS+1];
    logic [NW-1:0]        r_nr    [NS+1];
    logic [NW-1:0]        r_ni    [NS+1];
    logic [RW-1:0]        r_rr    [NS+1];
    logic [RW-1:0]        r_ri    [NS+1];
    logic [QW-1:0]        r_qr    [NS+1];
    logic [QW-1:0]        r_qi    [NS+1];

    // One step of shift, compare and subtract, with the quotient capped.
    function automatic logic [RW+QW-1:0] step(
        input logic [RW-1:0] rem, input logic [QW-1:0] q,
        input logic nb, input logic [DW-1:0] den);
        logic [RW:0]   t;
        logic          b;
        logic [QW:0]   nq;
        logic [QW-1:0] cap;
        logic [RW-1:0] nr;
        t   = {rem, nb};
        b   = (t >= {1'b0, {1'b0, den}});
        nr  = b ? RW'(t - {1'b0, {1'b0, den}}) : RW'(t);
        nq  = {q, b};
        cap = {1'b1, {(QW-1){1'b0}}};
        if (q[QW-1] || nq > {1'b0, cap}) begin
            nq = {1'b0, cap};
        end
        return {nr, nq[QW-1:0]};
    endfunction

    // Stage zero loads the operands.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_valid;
        end
        r_tag[0] <= i_tag;
        r_den[0] <= i_den;
        r_ngr[0] <= i_neg_re;
        r_ngi[0] <= i_neg_im;
        r_nr[0]  <= i_mag_re;
        r_ni[0]  <= i_mag_im;
        r_rr[0]  <= '0;
        r_ri[0]  <= '0;
        r_qr[0]  <= '0;
        r_qi[0]  <= '0;
    end

    // Each later stage brings down one numerator bit, then zeros for the fraction.
    for (genvar s = 0; s < NS; s++) begin : g_stage
        logic                nbr;
        logic                nbi;
        logic [RW+QW-1:0]    sr;
        logic [RW+QW-1:0]    si;
        if (s < NW) begin : g_int
            assign nbr = r_nr[s][NW-1-s];
            assign nbi = r_ni[s][NW-1-s];
        end else begin : g_frac
            assign nbr = 1'b0;
            assign nbi = 1'b0;
        end
        assign sr = step(r_rr[s], r_qr[s], nbr, r_den[s]);
        assign si = step(r_ri[s], r_qi[s], nbi, r_den[s]);
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s+1] <= 1'b0;
            end else begin
                r_vld[s+1] <= r_vld[s];
            end
            r_tag[s+1] <= r_tag[s];
            r_den[s+1] <= r_den[s];
            r_ngr[s+1] <= r_ngr[s];
            r_ngi[s+1] <= r_ngi[s];
            r_nr[s+1]  <= r_nr[s];
            r_ni[s+1]  <= r_ni[s];
            r_rr[s+1]  <= sr[RW+QW-1:QW];
            r_ri[s+1]  <= si[RW+QW-1:QW];
            r_qr[s+1]  <= sr[QW-1:0];
            r_qi[s+1]  <= si[QW-1:0];
        end
    end

    assign o_valid  = r_vld[NS];
    assign o_tag    = r_tag[NS];
    assign o_neg_re = r_ngr[NS];
    assign o_q_re   = r_qr[NS];
    assign o_neg_im = r_ngi[NS];
    assign o_q_im   = r_qi[NS];

endmodule

// ===== sv/complex_arithmetic_unit.sv =====
// Complex arithmetic unit top level: add, subtract, multiply and divide of Q-format operands.
// Depends on cau_pkg and cau_divider.
//
// Usage: raise i_start with i_mode and the four operand parts; busy never goes high,
// so a transfer takes place at every cycle that start is high. Each item gives one
// result on o_r_re, o_r_im, o_div_by_zero and o_saturated, marked by o_done for one
// cycle. Results leave in the order in which items entered.
// Every mode passes the same registers: 3 stages of operand, product and sum registers,
// then 2*DATA_WIDTH+FRAC_BITS+1 divider stages (a load stage, then one quotient bit
// per stage), then one output register. The default widths give Q8.8 operands.
// Throughput is one item per cycle; all modes travel the same pipeline so that
// order is kept. The receiver cannot stall; results are shown once.
// Synchronous active-low reset clears all valid bits; payload is not reset.
module complex_arithmetic_unit #(
    parameter int DATA_WIDTH = cau_pkg::DataWidthDef,
    parameter int FRAC_BITS  = cau_pkg::FracBitsDef
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   i_mode,
    input  logic signed [DATA_WIDTH-1:0] i_a_re,
    input  logic signed [DATA_WIDTH-1:0] i_a_im,
    input  logic signed [DATA_WIDTH-1:0] i_b_re,
    input  logic signed [DATA_WIDTH-1:0] i_b_im,
    output logic                         o_done,
    output logic signed [DATA_WIDTH-1:0] o_r_re,
    output logic signed [DATA_WIDTH-1:0] o_r_im,
    output logic                         o_div_by_zero,
    output logic                         o_saturated
);
    import cau_pkg::*;

    localparam int W  = DATA_WIDTH;
    localparam int PW = 2 * W;       // one product
    localparam int SW = 2 * W + 1;   // sum of two products, signed
    localparam int NW = 2 * W;       // magnitude of that sum
    localparam int DW = 2 * W;       // denominator magnitude, up to 2^(2W-1)
    localparam int QW = W + 1;       // capped quotient, up to 2^W
    localparam int MW = NW;          // result magnitude before packing
    localparam int TW = 2 + 1 + 2 * MW + 2;

    // Tag carried alongside the divider: mode, zero flag, and the non-divide results.
    typedef struct packed {
        t_op           op;
        logic          dz;
        logic          ngr;
        logic [MW-1:0] mr;
        logic          ngi;
        logic [MW-1:0] mi;
    } t_tag;

    assign busy = 1'b0;

    // Stage 1: register operands.
    logic                r1_v;
    t_op                 r1_op;
    logic signed [W-1:0] r1_ar, r1_ai, r1_br, r1_bi;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else begin
            r1_v <= start;
        end
        r1_op <= t_op'(i_mode);
        r1_ar <= i_a_re;
        r1_ai <= i_a_im;
        r1_br <= i_b_re;
        r1_bi <= i_b_im;
    end

    // Stage 2: the six products and the plain sums.
    logic                 r2_v;
    t_op                  r2_op;
    logic signed [PW-1:0] r2_p_rr, r2_p_ii, r2_p_ri, r2_p_ir, r2_p_bb, r2_p_cc;
    logic signed [W:0]    r2_s_re, r2_s_im;
    logic                 r2_dz;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else begin
            r2_v <= r1_v;
        end
        r2_op   <= r1_op;
        r2_p_rr <= PW'(r1_ar * r1_br);
        r2_p_ii <= PW'(r1_ai * r1_bi);
        r2_p_ri <= PW'(r1_ar * r1_bi);
        r2_p_ir <= PW'(r1_ai * r1_br);
        r2_p_bb <= PW'(r1_br * r1_br);
        r2_p_cc <= PW'(r1_bi * r1_bi);
        r2_dz   <= (r1_br == '0) && (r1_bi == '0);
        if (r1_op == OP_SUB) begin
            r2_s_re <= (W+1)'(r1_ar) - (W+1)'(r1_br);
            r2_s_im <= (W+1)'(r1_ai) - (W+1)'(r1_bi);
        end else begin
            r2_s_re <= (W+1)'(r1_ar) + (W+1)'(r1_br);
            r2_s_im <= (W+1)'(r1_ai) + (W+1)'(r1_bi);
        end
    end

    // Stage 3: sums of products, rounding for multiply, numerator sign and magnitude.
    logic signed [SW-1:0] c_re, c_im, c_den, c_rnd_re, c_rnd_im;
    logic [SW-1:0]        c_abs_re, c_abs_im;
    logic [SW-1:0]        c_half;
    always_comb begin
        c_half = (FRAC_BITS > 0) ? (SW'(1) << (FRAC_BITS - 1)) : '0;
        c_den  = SW'(r2_p_bb) + SW'(r2_p_cc);
        unique case (r2_op)
            OP_MUL: begin
                c_re = SW'(r2_p_rr) - SW'(r2_p_ii);
                c_im = SW'(r2_p_ri) + SW'(r2_p_ir);
            end
            OP_DIV: begin
                c_re = SW'(r2_p_rr) + SW'(r2_p_ii);
                c_im = SW'(r2_p_ir) - SW'(r2_p_ri);
            end
            default: begin
                c_re = SW'(r2_s_re);
                c_im = SW'(r2_s_im);
            end
        endcase
        c_abs_re = c_re[SW-1] ? SW'(-c_re) : c_re;
        c_abs_im = c_im[SW-1] ? SW'(-c_im) : c_im;
        c_rnd_re = SW'((c_abs_re + c_half) >> FRAC_BITS);
        c_rnd_im = SW'((c_abs_im + c_half) >> FRAC_BITS);
    end

    logic          r3_v;
    t_tag          r3_tag;
    logic          r3_ngr, r3_ngi;
    logic [NW-1:0] r3_nr, r3_ni;
    logic [DW-1:0] r3_den;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else begin
            r3_v <= r2_v;
        end
        r3_tag.op  <= r2_op;
        r3_tag.dz  <= r2_dz;
        r3_tag.ngr <= c_re[SW-1];
        r3_tag.ngi <= c_im[SW-1];
        if (r2_op == OP_MUL) begin
            r3_tag.mr <= MW'(c_rnd_re);
            r3_tag.mi <= MW'(c_rnd_im);
        end else begin
            r3_tag.mr <= MW'(c_abs_re);
            r3_tag.mi <= MW'(c_abs_im);
        end
        r3_ngr <= c_re[SW-1];
        r3_ngi <= c_im[SW-1];
        r3_nr  <= NW'(c_abs_re);
        r3_ni  <= NW'(c_abs_im);
        // A zero denominator is replaced by one; the result is discarded anyway.
        r3_den <= r2_dz ? DW'(1) : DW'(c_den);
    end

    // Divider pipeline.
    logic          d_v, d_ngr, d_ngi;
    logic [TW-1:0] d_tagb;
    logic [QW-1:0] d_qr, d_qi;
    t_tag          d_tag;

    cau_divider #(
        .NW(NW), .DW(DW), .FB(FRAC_BITS), .QW(QW), .TW(TW)
    ) u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r3_v),
        .i_tag    (r3_tag),
        .i_neg_re (r3_ngr),
        .i_mag_re (r3_nr),
        .i_neg_im (r3_ngi),
        .i_mag_im (r3_ni),
        .i_den    (r3_den),
        .o_valid  (d_v),
        .o_tag    (d_tagb),
        .o_neg_re (d_ngr),
        .o_q_re   (d_qr),
        .o_neg_im (d_ngi),
        .o_q_im   (d_qi)
    );
    assign d_tag = t_tag'(d_tagb);

    // Pack a sign and magnitude into the result width with saturation.
    function automatic logic [W:0] pack(input logic neg, input logic [MW-1:0] mag);
        logic [MW-1:0] lim;
        logic [W-1:0]  v;
        logic          s;
        lim = MW'(1) << (W - 1);
        s   = 1'b0;
        if (neg) begin
            if (mag > lim) begin
                s = 1'b1;
                v = W'(-lim);
            end else begin
                v = W'(-mag);
            end
        end else if (mag > lim - MW'(1)) begin
            s = 1'b1;
            v = W'(lim - MW'(1));
        end else begin
            v = W'(mag);
        end
        return {s, v};
    endfunction

    // Output stage: pick the result source and saturate.
    logic          o_sel_ngr, o_sel_ngi;
    logic [MW-1:0] o_sel_mr, o_sel_mi;
    logic [W:0]    o_pr, o_pi;
    always_comb begin
        if (d_tag.op == OP_DIV) begin
            o_sel_ngr = d_ngr && (d_qr != '0) && !d_tag.dz;
            o_sel_ngi = d_ngi && (d_qi != '0) && !d_tag.dz;
            o_sel_mr  = d_tag.dz ? '0 : MW'(d_qr);
            o_sel_mi  = d_tag.dz ? '0 : MW'(d_qi);
        end else begin
            o_sel_ngr = d_tag.ngr;
            o_sel_ngi = d_tag.ngi;
            o_sel_mr  = d_tag.mr;
            o_sel_mi  = d_tag.mi;
        end
        o_pr = pack(o_sel_ngr, o_sel_mr);
        o_pi = pack(o_sel_ngi, o_sel_mi);
    end

    logic         r_done, r_dz, r_sat;
    logic [W-1:0] r_re, r_im;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= d_v;
        end
        r_re  <= o_pr[W-1:0];
        r_im  <= o_pi[W-1:0];
        r_sat <= o_pr[W] | o_pi[W];
        r_dz  <= (d_tag.op == OP_DIV) && d_tag.dz;
    end

    assign o_done        = r_done;
    assign o_r_re        = r_re;
    assign o_r_im        = r_im;
    assign o_div_by_zero = r_dz;
    assign o_saturated   = r_sat;

endmodule
